[src/png_pass_layout_defines.svh]
// assertion macros for the png pass layout modules, used by ppl_tail
// expects clk and rst_n in the scope of each use
`ifndef PNG_PASS_LAYOUT_DEFINES_SVH
`define PNG_PASS_LAYOUT_DEFINES_SVH

// same-cycle implication
`define PPL_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define PPL_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[src/ppl_pkg.sv]
// types, widths, status codes and the Adam7 geometry table
// used by every module of the png pass layout block
package ppl_pkg;

  localparam int SIZE_BITS_DEF = 64;
  localparam int DIM_W         = 32;
  localparam int BPP_W         = 16;
  localparam int PFB_W         = 13;
  localparam int BITS_W        = DIM_W + BPP_W;
  localparam int RB_W          = BITS_W - 2;
  localparam int HI_W          = RB_W - DIM_W;
  localparam int PROD_W        = RB_W + DIM_W;
  localparam int MASK_W        = 8;
  localparam int ADAM7_PASSES  = 7;

  localparam logic [2:0] FULL_IDX   = 3'd7;
  localparam logic [7:0] MODE_NONE  = 8'd0;
  localparam logic [7:0] MODE_ADAM7 = 8'd1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO_BPP   = 3'd1,
    ST_BAD_METHOD = 3'd2,
    ST_OVERFLOW   = 3'd3,
    ST_NO_PASS    = 3'd4
  } ppl_status_t;

  typedef struct packed {
    logic [2:0] sx;
    logic [2:0] sy;
    logic [1:0] shx;
    logic [1:0] shy;
  } ppl_geom_t;

  typedef struct packed {
    logic             is_pass;
    logic [2:0]       num;
    ppl_status_t      status;
    logic             hdr_end;
    logic [PFB_W-1:0] pfb;
  } ppl_tag_t;

  typedef struct packed {
    ppl_tag_t         tag;
    logic [DIM_W-1:0] pw;
    logic [DIM_W-1:0] ph;
    logic [BPP_W-1:0] bpp;
  } ppl_item_t;

  typedef struct packed {
    ppl_tag_t          tag;
    logic [DIM_W-1:0]  pw;
    logic [DIM_W-1:0]  ph;
    logic [RB_W-1:0]   rb;
    logic [PROD_W-1:0] pb;
    logic              ovf;
  } ppl_res_t;

  // start and log2 step per axis; entry 7 is the full non-interlaced pass
  function automatic ppl_geom_t ppl_geom(input logic [2:0] idx);
    ppl_geom_t g;
    unique case (idx)
      3'd0: g = '{sx: 3'd0, sy: 3'd0, shx: 2'd3, shy: 2'd3};
      3'd1: g = '{sx: 3'd4, sy: 3'd0, shx: 2'd3, shy: 2'd3};
      3'd2: g = '{sx: 3'd0, sy: 3'd4, shx: 2'd2, shy: 2'd3};
      3'd3: g = '{sx: 3'd2, sy: 3'd0, shx: 2'd2, shy: 2'd2};
      3'd4: g = '{sx: 3'd0, sy: 3'd2, shx: 2'd1, shy: 2'd2};
      3'd5: g = '{sx: 3'd1, sy: 3'd0, shx: 2'd1, shy: 2'd1};
      3'd6: g = '{sx: 3'd0, sy: 3'd1, shx: 2'd0, shy: 2'd1};
      3'd7: g = '{sx: 3'd0, sy: 3'd0, shx: 2'd0, shy: 2'd0};
    endcase
    return g;
  endfunction

endpackage

[src/ppl_seq.sv]
// pass sequencer: holds one header and issues one pass request per ready cycle
// depends on ppl_pkg
module ppl_seq import ppl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [DIM_W-1:0] in_img_width,
  input  logic [DIM_W-1:0] in_img_height,
  input  logic [7:0]       in_samples_per_px,
  input  logic [7:0]       in_sample_depth,
  input  logic [7:0]       in_interlace_mode,
  output logic             item_valid,
  output ppl_item_t        item,
  input  logic             item_ready
);

  logic              hdr_v_r;
  logic [MASK_W-1:0] mask_r;
  logic [DIM_W-1:0]  w_r;
  logic [DIM_W-1:0]  h_r;
  logic [BPP_W-1:0]  bpp_r;
  logic [PFB_W-1:0]  pfb_r;
  ppl_status_t       stat_r;

  logic [MASK_W-1:0] mask_nxt;
  ppl_status_t       stat_nxt;
  logic [BPP_W-1:0]  bpp_in;
  logic [PFB_W-1:0]  pfb_in;
  logic [MASK_W-1:0] low;
  logic [MASK_W-1:0] rest;
  logic [2:0]        idx;
  ppl_geom_t         g;
  logic              fire;
  logic              acc;

  // lowest pending pass
  always_comb begin
    low  = mask_r & (~mask_r + MASK_W'(1));
    rest = mask_r & (mask_r - MASK_W'(1));
    idx  = 3'd0;
    for (int i = 0; i < MASK_W; i++) begin
      if (low[i]) idx = 3'(i);
    end
  end

  assign g = ppl_geom(idx);

  always_comb begin
    item.tag.is_pass = |mask_r;
    item.tag.num     = (idx == FULL_IDX) ? 3'd0 : idx;
    item.tag.status  = stat_r;
    item.tag.hdr_end = (rest == '0);
    item.tag.pfb     = pfb_r;
    item.pw          = ((w_r - DIM_W'(1) - DIM_W'(g.sx)) >> g.shx) + DIM_W'(1);
    item.ph          = ((h_r - DIM_W'(1) - DIM_W'(g.sy)) >> g.shy) + DIM_W'(1);
    item.bpp         = bpp_r;
  end

  assign item_valid = hdr_v_r;
  assign fire       = hdr_v_r && item_ready;
  assign in_stall   = hdr_v_r && !(fire && item.tag.hdr_end);
  assign acc        = in_valid && !in_stall;

  // header decode
  always_comb begin
    ppl_geom_t gp;
    logic [ADAM7_PASSES-1:0] m;
    bpp_in = BPP_W'(in_samples_per_px) * BPP_W'(in_sample_depth);
    pfb_in = (bpp_in < BPP_W'(8)) ? PFB_W'(1)
                                  : PFB_W'(((BPP_W+1)'(bpp_in) + (BPP_W+1)'(7)) >> 3);
    for (int p = 0; p < ADAM7_PASSES; p++) begin
      gp   = ppl_geom(3'(p));
      m[p] = (in_img_width > DIM_W'(gp.sx)) && (in_img_height > DIM_W'(gp.sy));
    end
    priority if (bpp_in == '0) begin
      mask_nxt = '0;
      stat_nxt = ST_ZERO_BPP;
    end else if (in_interlace_mode == MODE_NONE) begin
      mask_nxt = (in_img_width != '0 && in_img_height != '0) ? 8'h80 : '0;
      stat_nxt = ST_OK;
    end else if (in_interlace_mode != MODE_ADAM7) begin
      mask_nxt = '0;
      stat_nxt = ST_BAD_METHOD;
    end else begin
      mask_nxt = {1'b0, m};
      stat_nxt = (m == '0) ? ST_NO_PASS : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_v_r <= 1'b0;
      mask_r  <= '0;
    end else if (acc) begin
      hdr_v_r <= 1'b1;
      mask_r  <= mask_nxt;
    end else if (fire) begin
      if (item.tag.hdr_end) hdr_v_r <= 1'b0;
      mask_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      w_r    <= in_img_width;
      h_r    <= in_img_height;
      bpp_r  <= bpp_in;
      pfb_r  <= pfb_in;
      stat_r <= stat_nxt;
    end
  end

endmodule

[src/ppl_calc.sv]
// five-stage size pipeline: row bits, row bytes, split product, pass bytes
// depends on ppl_pkg
module ppl_calc import ppl_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  ppl_item_t item,
  output logic      item_ready,
  output logic      res_valid,
  output ppl_res_t  res,
  input  logic      res_ready
);

  localparam int NSTG = 5;
  localparam logic [PROD_W-1:0] SIZE_MAX =
    {{(PROD_W-SIZE_BITS){1'b0}}, {SIZE_BITS{1'b1}}};

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;

  ppl_item_t s1_r;

  ppl_tag_t          s2_tag_r;
  logic [DIM_W-1:0]  s2_pw_r, s2_ph_r;
  logic [BITS_W-1:0] s2_bits_r;

  ppl_tag_t          s3_tag_r;
  logic [DIM_W-1:0]  s3_pw_r, s3_ph_r;
  logic [RB_W-1:0]   s3_rb_r, s3_stride_r;
  logic              s3_ovf_r;

  ppl_tag_t            s4_tag_r;
  logic [DIM_W-1:0]    s4_pw_r, s4_ph_r;
  logic [RB_W-1:0]     s4_rb_r;
  logic [2*DIM_W-1:0]  s4_plo_r;
  logic [HI_W+DIM_W-1:0] s4_phi_r;
  logic                s4_ovf_r;

  ppl_res_t s5_r;

  logic [BITS_W-1:0]     bits1;
  logic [BITS_W:0]       sum7;
  logic [RB_W-1:0]       rb2;
  logic                  ovf2;
  logic [2*DIM_W-1:0]    plo3;
  logic [HI_W+DIM_W-1:0] phi3;
  logic [PROD_W-1:0]     pb4;
  logic                  ovf4;

  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || res_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign item_ready = rdy[0];
  assign res_valid  = v_r[NSTG-1];
  assign res        = s5_r;

  assign bits1 = BITS_W'(s1_r.pw) * BITS_W'(s1_r.bpp);

  always_comb begin
    sum7 = (BITS_W+1)'(s2_bits_r) + (BITS_W+1)'(7);
    rb2  = RB_W'(sum7 >> 3);
    ovf2 = (PROD_W'(s2_bits_r) > SIZE_MAX - PROD_W'(7)) ||
           (PROD_W'(rb2) > SIZE_MAX - PROD_W'(1));
  end

  // stride times height as two partial products
  assign plo3 = (2*DIM_W)'(s3_stride_r[DIM_W-1:0]) * (2*DIM_W)'(s3_ph_r);
  assign phi3 = (HI_W+DIM_W)'(s3_stride_r[RB_W-1:DIM_W]) * (HI_W+DIM_W)'(s3_ph_r);

  assign pb4  = (PROD_W'(s4_phi_r) << DIM_W) + PROD_W'(s4_plo_r);
  assign ovf4 = s4_ovf_r || (pb4 > SIZE_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= item_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) s1_r <= item;
    if (rdy[1]) begin
      s2_tag_r  <= s1_r.tag;
      s2_pw_r   <= s1_r.pw;
      s2_ph_r   <= s1_r.ph;
      s2_bits_r <= bits1;
    end
    if (rdy[2]) begin
      s3_tag_r    <= s2_tag_r;
      s3_pw_r     <= s2_pw_r;
      s3_ph_r     <= s2_ph_r;
      s3_rb_r     <= rb2;
      s3_stride_r <= rb2 + RB_W'(1);
      s3_ovf_r    <= ovf2;
    end
    if (rdy[3]) begin
      s4_tag_r <= s3_tag_r;
      s4_pw_r  <= s3_pw_r;
      s4_ph_r  <= s3_ph_r;
      s4_rb_r  <= s3_rb_r;
      s4_plo_r <= plo3;
      s4_phi_r <= phi3;
      s4_ovf_r <= s3_ovf_r;
    end
    if (rdy[4]) begin
      s5_r.tag <= s4_tag_r;
      s5_r.pw  <= s4_pw_r;
      s5_r.ph  <= s4_ph_r;
      s5_r.rb  <= s4_rb_r;
      s5_r.pb  <= pb4;
      s5_r.ovf <= ovf4;
    end
  end

endmodule

[src/ppl_tail.sv]
// result stage: running total, overflow close-out, output register
// depends on ppl_pkg and png_pass_layout_defines.svh
`include "png_pass_layout_defines.svh"

module ppl_tail import ppl_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  ppl_res_t         res,
  output logic             res_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_pass_number,
  output logic             out_pass_valid,
  output logic [DIM_W-1:0] out_pass_width,
  output logic [DIM_W-1:0] out_pass_height,
  output logic [63:0]      out_line_bytes,
  output logic [63:0]      out_pass_bytes,
  output logic [63:0]      out_running_total,
  output logic [PFB_W-1:0] out_pixel_filter_bytes,
  output logic [2:0]       out_status,
  output logic             out_last
);

  localparam logic [PROD_W-1:0] SIZE_MAX =
    {{(PROD_W-SIZE_BITS){1'b0}}, {SIZE_BITS{1'b1}}};

  logic                 out_v_r;
  logic                 dead_r, dead_nxt;
  logic [SIZE_BITS-1:0] total_r, total_nxt;

  logic [2:0]       out_pass_number_r, num_nxt;
  logic             out_pass_valid_r, pv_nxt;
  logic [DIM_W-1:0] out_pass_width_r, pw_nxt;
  logic [DIM_W-1:0] out_pass_height_r, ph_nxt;
  logic [63:0]      out_line_bytes_r, rb_nxt;
  logic [63:0]      out_pass_bytes_r, pb_nxt;
  logic [63:0]      out_running_total_r, tot_nxt;
  logic [PFB_W-1:0] out_pfb_r;
  ppl_status_t      out_status_r, st_nxt;
  logic             out_last_r, last_nxt;

  logic              take;
  logic              emit;
  logic [PROD_W-1:0] sum;
  logic              ovf;

  assign res_ready = !out_v_r || !out_stall;
  assign take      = res_valid && res_ready;
  assign sum       = PROD_W'(total_r) + res.pb;
  assign ovf       = res.ovf || (sum > SIZE_MAX);

  always_comb begin
    emit      = 1'b0;
    dead_nxt  = dead_r;
    total_nxt = total_r;
    num_nxt   = res.tag.num;
    pv_nxt    = 1'b0;
    pw_nxt    = '0;
    ph_nxt    = '0;
    rb_nxt    = '0;
    pb_nxt    = '0;
    tot_nxt   = '0;
    st_nxt    = res.tag.status;
    last_nxt  = 1'b1;
    if (take) begin
      priority if (dead_r) begin
        // rest of a header that already closed on overflow
        dead_nxt = !res.tag.hdr_end;
      end else if (!res.tag.is_pass) begin
        emit      = 1'b1;
        total_nxt = '0;
      end else if (ovf) begin
        emit      = 1'b1;
        st_nxt    = ST_OVERFLOW;
        total_nxt = '0;
        dead_nxt  = !res.tag.hdr_end;
      end else begin
        emit      = 1'b1;
        pv_nxt    = 1'b1;
        pw_nxt    = res.pw;
        ph_nxt    = res.ph;
        rb_nxt    = 64'(res.rb);
        pb_nxt    = 64'(res.pb);
        tot_nxt   = 64'(sum);
        last_nxt  = res.tag.hdr_end;
        total_nxt = res.tag.hdr_end ? '0 : SIZE_BITS'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      dead_r  <= 1'b0;
      total_r <= '0;
    end else begin
      out_v_r <= emit || (out_v_r && out_stall);
      dead_r  <= dead_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pass_number_r   <= num_nxt;
      out_pass_valid_r    <= pv_nxt;
      out_pass_width_r    <= pw_nxt;
      out_pass_height_r   <= ph_nxt;
      out_line_bytes_r    <= rb_nxt;
      out_pass_bytes_r    <= pb_nxt;
      out_running_total_r <= tot_nxt;
      out_pfb_r           <= res.tag.pfb;
      out_status_r        <= st_nxt;
      out_last_r          <= last_nxt;
    end
  end

  assign out_valid              = out_v_r;
  assign out_pass_number        = out_pass_number_r;
  assign out_pass_valid         = out_pass_valid_r;
  assign out_pass_width         = out_pass_width_r;
  assign out_pass_height        = out_pass_height_r;
  assign out_line_bytes         = out_line_bytes_r;
  assign out_pass_bytes         = out_pass_bytes_r;
  assign out_running_total      = out_running_total_r;
  assign out_pixel_filter_bytes = out_pfb_r;
  assign out_status             = out_status_r;
  assign out_last               = out_last_r;

  `PPL_ASSERT_IMPL(a_close_is_last, out_v_r && !out_pass_valid_r, out_last_r, "closing result without last")
  `PPL_ASSERT_IMPL(a_err_not_pass, out_v_r && out_status_r != ST_OK, !out_pass_valid_r, "error status on a pass result")
  `PPL_ASSERT_IMPL(a_total_covers, out_v_r && out_pass_valid_r, out_running_total_r >= out_pass_bytes_r, "running total below pass bytes")
  `PPL_ASSERT_NEXT(a_total_cleared, emit && last_nxt, total_r == '0, "total not cleared after last result")

endmodule

[src/png_pass_layout.sv]
// top level of the png pass layout block: sequencer, size pipeline, result stage
// depends on ppl_pkg, ppl_seq, ppl_calc and ppl_tail
//
// channel | handshake            | payload
// in      | in_valid / in_stall  | img_width, img_height, samples_per_px, sample_depth,
//         |                      | interlace_mode
// out     | out_valid / out_stall| pass_number, pass_valid, pass_width, pass_height, line_bytes,
//         |                      | pass_bytes, running_total, pixel_filter_bytes, status, last
//
// one result per cycle while out_stall is low; a header holds the sequencer for one request
// per non-empty pass, or one when it has none, so a full Adam7 header issues seven requests
// a header's results pass the sequencer register, each pipeline stage and the output register
// synchronous active-low reset empties the sequencer, the five pipeline stages and the output
// out_stall halts only the stages that are full; bubbles still close up behind it
module png_pass_layout import ppl_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [DIM_W-1:0] in_img_width,
  input  logic [DIM_W-1:0] in_img_height,
  input  logic [7:0]       in_samples_per_px,
  input  logic [7:0]       in_sample_depth,
  input  logic [7:0]       in_interlace_mode,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_pass_number,
  output logic             out_pass_valid,
  output logic [DIM_W-1:0] out_pass_width,
  output logic [DIM_W-1:0] out_pass_height,
  output logic [63:0]      out_line_bytes,
  output logic [63:0]      out_pass_bytes,
  output logic [63:0]      out_running_total,
  output logic [PFB_W-1:0] out_pixel_filter_bytes,
  output logic [2:0]       out_status,
  output logic             out_last
);

  logic      item_valid;
  ppl_item_t item;
  logic      item_ready;
  logic      res_valid;
  ppl_res_t  res;
  logic      res_ready;

  ppl_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_img_width      (in_img_width),
    .in_img_height     (in_img_height),
    .in_samples_per_px (in_samples_per_px),
    .in_sample_depth   (in_sample_depth),
    .in_interlace_mode (in_interlace_mode),
    .item_valid        (item_valid),
    .item              (item),
    .item_ready        (item_ready)
  );

  ppl_calc #(
    .SIZE_BITS (SIZE_BITS)
  ) u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  ppl_tail #(
    .SIZE_BITS (SIZE_BITS)
  ) u_tail (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .res_valid              (res_valid),
    .res                    (res),
    .res_ready              (res_ready),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_pass_number        (out_pass_number),
    .out_pass_valid         (out_pass_valid),
    .out_pass_width         (out_pass_width),
    .out_pass_height        (out_pass_height),
    .out_line_bytes         (out_line_bytes),
    .out_pass_bytes         (out_pass_bytes),
    .out_running_total      (out_running_total),
    .out_pixel_filter_bytes (out_pixel_filter_bytes),
    .out_status             (out_status),
    .out_last               (out_last)
  );

endmodule
